/* hdl/rds_block_error_trapping_decoder_defines.svh */
// Assertion macros for the checker file of the RDS block decoder.
`ifndef RDS_BLOCK_ERROR_TRAPPING_DECODER_DEFINES_SVH
`define RDS_BLOCK_ERROR_TRAPPING_DECODER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RDSBET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RDSBET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/rdsbet_pkg.sv */
`timescale 1ns / 1ps

package rdsbet_pkg;

  localparam int unsigned BlkBits  = 26;
  localparam int unsigned InfBits  = 16;
  localparam int unsigned ChkBits  = 10;

  localparam logic [10:0] GenPoly  = 11'h5B9;
  localparam logic [10:0] InjPoly  = 11'h31B;
  localparam logic [9:0]  TrapMask = 10'((1 << 5) - 1);

  // Split of the 26 serial syndrome steps over the pipeline stages.
  localparam int unsigned NumSynStages = 4;
  localparam int unsigned SynHi  [NumSynStages] = '{25, 18, 11, 5};
  localparam int unsigned SynLen [NumSynStages] = '{7, 7, 6, 6};

  // Split of the 26 trapping iterations over the pipeline stages.
  localparam int unsigned NumTrapStages = 4;
  localparam int unsigned TrapLo  [NumTrapStages] = '{0, 7, 14, 20};
  localparam int unsigned TrapLen [NumTrapStages] = '{7, 7, 6, 6};

  typedef enum logic [1:0] {
    StValid     = 2'd0,
    StCorrected = 2'd1,
    StUncorr    = 2'd2
  } status_e;

  typedef struct packed {
    logic clean;    // syndrome was zero on arrival
    logic trapped;  // burst was trapped within the allowed shifts
    logic chk_hit;  // correction pattern touches the checkword
  } tag_t;

  typedef struct packed {
    logic [9:0] syn;
    logic [4:0] cnt;
    logic       found;
  } trap_t;

  // One step of the syndrome register: shift, inject on a one bit, reduce.
  function automatic logic [9:0] syn_step(logic [9:0] s, logic b);
    logic [10:0] t;
    t = {s, 1'b0} ^ (b ? InjPoly : 11'd0);
    if (t[10]) begin
      t = t ^ GenPoly;
    end
    return t[9:0];
  endfunction

  // Runs n syndrome steps over block bits hi down to hi-n+1.
  function automatic logic [9:0] syn_run(logic [9:0] s, logic [25:0] blk,
                                         int unsigned hi, int unsigned n);
    logic [9:0]  r;
    logic [25:0] w;
    r = s;
    w = blk << (BlkBits - 1 - hi);
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        r = syn_step(r, w[25-k]);
      end
    end
    return r;
  endfunction

  // Runs trapping iterations lo .. lo+n-1 until the low five bits clear.
  function automatic trap_t trap_run(trap_t t_in, int unsigned lo, int unsigned n);
    trap_t t;
    t = t_in;
    for (int k = 0; k < 8; k++) begin
      if (k < n && !t.found) begin
        if ((t.syn & TrapMask) == 10'd0) begin
          t.found = 1'b1;
          t.cnt   = 5'(lo + k);
        end else begin
          t.syn = syn_step(t.syn, 1'b0);
        end
      end
    end
    return t;
  endfunction

endpackage

/* hdl/rdsbet_syn_pipe.sv */
`timescale 1ns / 1ps

module rdsbet_syn_pipe
  import rdsbet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [25:0] block_i,
  input  tag_t        tag_i,
  output logic        valid_o,
  output logic [25:0] block_o,
  output logic [9:0]  syn_o,
  output tag_t        tag_o
);

  logic [NumSynStages-1:0] vld_q;
  logic [25:0]             blk_q [NumSynStages];
  logic [9:0]              syn_q [NumSynStages];
  tag_t                    tag_q [NumSynStages];

  for (genvar g = 0; g < NumSynStages; g++) begin : g_stage
    logic        vld_in;
    logic [25:0] blk_in;
    logic [9:0]  syn_in;
    tag_t        tag_in;
    logic [9:0]  syn_d;

    if (g == 0) begin : g_first
      assign vld_in = valid_i;
      assign blk_in = block_i;
      assign syn_in = 10'd0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign blk_in = blk_q[g-1];
      assign syn_in = syn_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    assign syn_d = syn_run(syn_in, blk_in, SynHi[g], SynLen[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i && vld_in) begin
        blk_q[g] <= blk_in;
        syn_q[g] <= syn_d;
        tag_q[g] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NumSynStages-1];
  assign block_o = blk_q[NumSynStages-1];
  assign syn_o   = syn_q[NumSynStages-1];
  assign tag_o   = tag_q[NumSynStages-1];

endmodule

/* hdl/rdsbet_trap_pipe.sv */
`timescale 1ns / 1ps

module rdsbet_trap_pipe
  import rdsbet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [25:0] block_i,
  input  logic [9:0]  syn_i,
  output logic        valid_o,
  output logic [25:0] fixed_o,
  output tag_t        tag_o
);

  logic [NumTrapStages-1:0] vld_q;
  logic [25:0]              blk_q   [NumTrapStages];
  trap_t                    st_q    [NumTrapStages];
  logic                     clean_q [NumTrapStages];

  for (genvar g = 0; g < NumTrapStages; g++) begin : g_stage
    logic        vld_in;
    logic [25:0] blk_in;
    trap_t       st_in;
    logic        clean_in;
    trap_t       st_d;

    if (g == 0) begin : g_first
      assign vld_in   = valid_i;
      assign blk_in   = block_i;
      assign st_in    = '{syn: syn_i, cnt: 5'd0, found: 1'b0};
      assign clean_in = (syn_i == 10'd0);
    end else begin : g_next
      assign vld_in   = vld_q[g-1];
      assign blk_in   = blk_q[g-1];
      assign st_in    = st_q[g-1];
      assign clean_in = clean_q[g-1];
    end

    assign st_d = trap_run(st_in, TrapLo[g], TrapLen[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i && vld_in) begin
        blk_q[g]   <= blk_in;
        st_q[g]    <= st_d;
        clean_q[g] <= clean_in;
      end
    end
  end

  // The trapped burst sits at bits 25..16 and is rotated right by the shift count.
  trap_t       last;
  logic [25:0] burst;
  logic [51:0] dbl;
  logic [25:0] err;
  logic        vld_q_out;
  logic [25:0] fix_q;
  tag_t        tag_q;
  logic [25:0] fix_d;
  tag_t        tag_d;

  assign last  = st_q[NumTrapStages-1];
  assign burst = {last.syn, 16'd0};
  assign dbl   = {burst, burst} >> last.cnt;
  assign err   = last.found ? dbl[25:0] : 26'd0;
  assign fix_d = blk_q[NumTrapStages-1] ^ err;
  assign tag_d = '{clean:   clean_q[NumTrapStages-1],
                   trapped: last.found,
                   chk_hit: |err[ChkBits-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q_out <= 1'b0;
    end else if (en_i) begin
      vld_q_out <= vld_q[NumTrapStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && vld_q[NumTrapStages-1]) begin
      fix_q <= fix_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = vld_q_out;
  assign fixed_o = fix_q;
  assign tag_o   = tag_q;

endmodule

/* hdl/rds_block_error_trapping_decoder.sv */
`timescale 1ns / 1ps

// RDS (26,16) block decoder with burst error trapping. Each transfer on the input
// carries one received block and the offset word of its expected position; each
// block yields exactly one result: the 16 info bits with status valid, corrected
// or uncorrectable (info reads zero when uncorrectable). The datapath is a fixed
// 14-stage pipeline: four stages of serial syndrome steps, four stages of trapping
// shifts, one correction stage, four stages that recompute the syndrome of the
// patched block, and the output register. A block can enter every cycle unless a
// result is held at the output, so the throughput is one block per cycle; the whole
// pipeline holds while a result waits at the output.
module rds_block_error_trapping_decoder
  import rdsbet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [25:0] received_block_i,
  input  logic [9:0]  offset_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] info_word_o,
  output logic [1:0]  decode_status_o
);

  logic        en;
  logic [25:0] blk_in;

  logic        syn_vld;
  logic [25:0] syn_blk;
  logic [9:0]  syn_val;

  logic        trp_vld;
  logic [25:0] trp_fix;
  tag_t        trp_tag;

  logic        chk_vld;
  logic [25:0] chk_blk;
  logic [9:0]  chk_syn;
  tag_t        chk_tag;

  logic        out_valid_q;
  logic [15:0] info_q, info_d;
  status_e     status_q, status_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign blk_in     = received_block_i ^ {16'd0, offset_word_i};

  rdsbet_syn_pipe u_syn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .block_i (blk_in),
    .tag_i   ('0),
    .valid_o (syn_vld),
    .block_o (syn_blk),
    .syn_o   (syn_val),
    .tag_o   ()
  );

  rdsbet_trap_pipe u_trap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (syn_vld),
    .block_i (syn_blk),
    .syn_i   (syn_val),
    .valid_o (trp_vld),
    .fixed_o (trp_fix),
    .tag_o   (trp_tag)
  );

  rdsbet_syn_pipe u_recheck (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trp_vld),
    .block_i (trp_fix),
    .tag_i   (trp_tag),
    .valid_o (chk_vld),
    .block_o (chk_blk),
    .syn_o   (chk_syn),
    .tag_o   (chk_tag)
  );

  // A clean block passes through the trap stages unchanged.
  always_comb begin
    if (chk_tag.clean) begin
      status_d = StValid;
      info_d   = chk_blk[BlkBits-1:ChkBits];
    end else if (chk_tag.trapped && !chk_tag.chk_hit && chk_syn == 10'd0) begin
      status_d = StCorrected;
      info_d   = chk_blk[BlkBits-1:ChkBits];
    end else begin
      status_d = StUncorr;
      info_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chk_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && chk_vld) begin
      info_q   <= info_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign info_word_o     = info_q;
  assign decode_status_o = status_q;

endmodule

/* hdl/rdsbet_checker.sv */
`timescale 1ns / 1ps

`include "rds_block_error_trapping_decoder_defines.svh"

module rdsbet_checker
  import rdsbet_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [25:0] received_block_i,
  input logic [9:0]  offset_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] info_word_o,
  input logic [1:0]  decode_status_o
);

  logic        in_stall;
  logic [35:0] in_word;
  logic        out_stall;
  logic [17:0] out_word;
  logic        out_uncorr;

  assign in_stall   = in_valid_i && !in_ready_o;
  assign in_word    = {received_block_i, offset_word_i};
  assign out_stall  = out_valid_o && !out_ready_i;
  assign out_word   = {info_word_o, decode_status_o};
  assign out_uncorr = out_valid_o && decode_status_o == StUncorr;

  `RDSBET_ASSERT(a_in_hold, in_stall |=> in_valid_i && $stable(in_word), "held input changed")

  `RDSBET_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_word), "held result changed")

  `RDSBET_ASSERT(a_status_code, out_valid_o |-> decode_status_o <= StUncorr, "illegal status code")

  `RDSBET_ASSERT(a_uncorr_zero, out_uncorr |-> info_word_o == 16'd0, "uncorrectable info not zero")

  `RDSBET_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i), "ready ignores stall")

endmodule

bind rds_block_error_trapping_decoder rdsbet_checker u_rdsbet_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rdsbet_pkg::*;

  localparam int          ClkHalf       = 4;
  localparam logic [10:0] SynGen        = 11'h5B9;
  localparam logic [10:0] SynInj        = 11'h31B;
  localparam int          NumPhases     = 5;
  localparam int          IdlePct  [NumPhases] = '{0, 52, 0, 18, 0};
  localparam int          StallPct [NumPhases] = '{0, 0, 52, 18, 0};
  localparam int          BlocksPerPhase = 330;
  localparam int          DrainCycles   = 40;
  localparam int          WatchdogLimit = 2000;
  localparam int          NumFlipBits   = 5;
  localparam int          FlipBits [NumFlipBits] = '{25, 16, 10, 9, 0};

  typedef struct packed {
    logic [25:0] blk;
    logic [9:0]  off;
  } rx_block_t;

  typedef struct packed {
    logic [15:0] info;
    status_e     status;
    logic        trapped;
    logic        chk_hit;
  } decode_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [25:0] received_block_i = '0;
  logic [9:0]  offset_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] info_word_o;
  logic [1:0]  decode_status_o;

  rx_block_t   block_q[$];
  decode_t     decoded_q[$];
  logic [9:0]  chk_of_syn [1024];
  rx_block_t   drive_item;
  decode_t     want;
  logic        in_taken = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;

  rds_block_error_trapping_decoder uut (.*);

  always #(ClkHalf) clk_i = ~clk_i;

  // Serial syndrome over bits 25 down to 0, as the block's divider forms it.
  function automatic logic [9:0] block_syndrome(logic [25:0] blk);
    logic [10:0] s;
    s = '0;
    for (int k = 25; k >= 0; k--) begin
      s = {s[9:0], 1'b0};
      if (blk[k]) s = s ^ SynInj;
      if (s[10]) s = s ^ SynGen;
    end
    return s[9:0];
  endfunction

  function automatic decode_t decode_block(logic [25:0] rx, logic [9:0] off);
    decode_t     d;
    logic [25:0] blk;
    logic [25:0] err;
    logic [25:0] fixed;
    logic [51:0] twice;
    logic [10:0] t;
    logic [9:0]  s;
    logic        done;
    blk       = rx ^ {16'd0, off};
    d.info    = '0;
    d.status  = StUncorr;
    d.trapped = 1'b0;
    d.chk_hit = 1'b0;
    s = block_syndrome(blk);
    if (s == 10'd0) begin
      d.info   = blk[25:10];
      d.status = StValid;
    end else begin
      done = 1'b0;
      for (int i = 0; i < 26; i++) begin
        if (!done) begin
          if (s[4:0] == 5'd0) begin
            done      = 1'b1;
            d.trapped = 1'b1;
            // Burst sits at bits 25..16 and is rotated right by the shift count.
            twice     = {s, 16'd0, s, 16'd0};
            err       = 26'(twice >> i);
            fixed     = blk ^ err;
            d.chk_hit = (err[9:0] != 10'd0);
            if (!d.chk_hit && block_syndrome(fixed) == 10'd0) begin
              d.info   = fixed[25:10];
              d.status = StCorrected;
            end
          end else begin
            t = {s, 1'b0};
            if (t[10]) t = t ^ SynGen;
            s = t[9:0];
          end
        end
      end
    end
    return d;
  endfunction

  function automatic logic [25:0] codeword(logic [15:0] info);
    return {info, chk_of_syn[block_syndrome({info, 10'd0})]};
  endfunction

  function automatic rx_block_t rx_item(logic [25:0] blk, logic [9:0] off);
    rx_block_t b;
    b.blk = blk;
    b.off = off;
    return b;
  endfunction

  // Clean codewords, codewords with short bursts, some scattered errors and some noise.
  function automatic rx_block_t make_block();
    rx_block_t   b;
    int          kind;
    int          len;
    logic [4:0]  pat;
    logic [25:0] cw;
    logic [25:0] err;
    kind  = $urandom_range(99);
    b.off = 10'($urandom);
    cw    = codeword(16'($urandom));
    err   = '0;
    if (kind >= 20 && kind < 65) begin
      len = $urandom_range(5, 1);
      pat = 5'($urandom) & 5'((1 << len) - 1);
      pat[0] = 1'b1;
      pat[len-1] = 1'b1;
      err = 26'(pat) << $urandom_range(26 - len);
    end else if (kind >= 65 && kind < 82) begin
      repeat ($urandom_range(4, 2)) err[$urandom_range(25)] = 1'b1;
    end else if (kind >= 82) begin
      cw = 26'($urandom);
    end
    b.blk = cw ^ err ^ {16'd0, b.off};
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic wait_drained();
    while (block_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: a new transfer is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if (!in_valid_i || in_taken) begin
        if (block_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drive_item = block_q.pop_front();
          received_block_i <= drive_item.blk;
          offset_word_i    <= drive_item.off;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decoded_q.push_back(decode_block(received_block_i, offset_word_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result info=%h status=%0d",
                                    info_word_o, decode_status_o));
        end else begin
          want = decoded_q.pop_front();
          if (info_word_o !== want.info)
            report_mismatch($sformatf("info_word %h, expected %h", info_word_o, want.info));
          if (decode_status_o !== want.status)
            report_mismatch($sformatf("decode_status %0d, expected %0d",
                                      decode_status_o, want.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] no transfer for %0d cycles", $time, WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rx_block_t cand;
    decode_t   guess;
    logic [2:0] found;
    logic [9:0] off;
    for (int c = 0; c < 1024; c++) chk_of_syn[block_syndrome({16'd0, 10'(c)})] = 10'(c);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed blocks: field extremes, clean words, single flips, bursts.
    block_q.push_back(rx_item(26'd0, 10'd0));
    block_q.push_back(rx_item(26'h3FFFFFF, 10'h3FF));
    block_q.push_back(rx_item(26'h3FFFFFF, 10'd0));
    block_q.push_back(rx_item(codeword(16'hFFFF) ^ 26'h3FF, 10'h3FF));
    block_q.push_back(rx_item(codeword(16'h8001) ^ 26'h155, 10'h155));
    for (int n = 0; n < NumFlipBits; n++) begin
      block_q.push_back(rx_item(codeword(16'hA5C3) ^ (26'd1 << FlipBits[n]), 10'd0));
    end
    off = 10'h2AA;
    block_q.push_back(rx_item(codeword(16'h1234) ^ (26'h1F << 21) ^ {16'd0, off}, off));
    block_q.push_back(rx_item(codeword(16'h5A5A) ^ (26'h15 << 12), 10'd0));
    block_q.push_back(rx_item(codeword(16'h0F0F) ^ (26'h1F << 8), 10'd0));

    // A block whose burst never traps, one whose pattern hits the checkword,
    // and one whose patched block still fails the syndrome check.
    found = 3'b000;
    for (int n = 0; n < 20000 && found != 3'b111; n++) begin
      cand  = make_block();
      guess = decode_block(cand.blk, cand.off);
      if (guess.status == StUncorr) begin
        if (!guess.trapped && !found[0]) begin
          found[0] = 1'b1;
          block_q.push_back(cand);
        end else if (guess.trapped && guess.chk_hit && !found[1]) begin
          found[1] = 1'b1;
          block_q.push_back(cand);
        end else if (guess.trapped && !guess.chk_hit && !found[2]) begin
          found[2] = 1'b1;
          block_q.push_back(cand);
        end
      end
    end
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      idle_pct  = IdlePct[p];
      stall_pct = StallPct[p];
      repeat (BlocksPerPhase) block_q.push_back(make_block());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
